// ===== hw/rtl/mtpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpa_pkg
// Shared constants for the media tag packet aggregator.
// ----------------------------------------------------------------------------
package mtpa_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PACKET_DEF = 16384;
  localparam int MAX_CHUNKS_DEF = 63;

  // Fixed field widths
  localparam int TAG_W    = 20;
  localparam int POS_W    = 32;
  localparam int PLEN_W   = 15;
  localparam int THRESH_W = 15;

  // Register map (word index)
  localparam logic REG_FLUSH_LIMIT = 1'b0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd8192;

  // Input action codes
  localparam logic ACT_TAG    = 1'b0;
  localparam logic ACT_HEADER = 1'b1;

endpackage

// ===== hw/rtl/media_tag_packet_aggregator.sv =====
// ----------------------------------------------------------------------------
// media_tag_packet_aggregator
// Descriptor-level packetizer: aggregates small media tags, flushes on
// keyframes, overflow or threshold, and splits large tags into chunks.
// ----------------------------------------------------------------------------
// One input transaction is handled at a time by a small sequencer around a
// single shared 32-bit adder. Steps per tag: accept, then classify (the
// adder forms buffered + tag_length and it is compared with MAX_PACKET and
// the flush limit), then one emit step per outgoing packet, plus a re-buffer
// step on the threshold path. Every packet waits for room in the output
// register, so output back-pressure on m_tready stalls the sequencer; tag
// flushes and chunks advance the stream position through the adder, while a
// header sets it to the header length. s_tready is high only while the
// sequencer is idle; the last packet of the previous tag may still be
// waiting in the output register at that time. Tags longer than
// MAX_CHUNKS * MAX_PACKET bytes give a single rejected transaction and leave
// the state untouched. The flush limit is written through the APB port at
// byte address 0 and must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module media_tag_packet_aggregator #(
  parameter int MAX_PACKET = mtpa_pkg::MAX_PACKET_DEF,
  parameter int MAX_CHUNKS = mtpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] tag_length, [23:20] zero
  input  logic [1:0]  s_tuser,   // [0] action, [1] is_keyframe
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] packet_position, [46:32] packet_length,
                                 // [66:47] chunk_offset, [71:67] zero
  output logic [2:0]  m_tuser,   // [0] from_buffer, [1] continuation, [2] rejected
  output logic        m_tlast,   // last_result
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TAG_W    = mtpa_pkg::TAG_W;
  localparam int POS_W    = mtpa_pkg::POS_W;
  localparam int PLEN_W   = mtpa_pkg::PLEN_W;
  localparam int THRESH_W = mtpa_pkg::THRESH_W;
  // buffered byte count never exceeds MAX_PACKET
  localparam int BUF_W    = $clog2(MAX_PACKET + 1);
  localparam logic [POS_W-1:0] MAX_PKT_C = POS_W'(MAX_PACKET);
  localparam logic [POS_W-1:0] MAX_TAG_C = POS_W'(MAX_CHUNKS * MAX_PACKET);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH,
    ST_CHUNK,
    ST_REBUF,
    ST_REJECT
  } st_t;

  st_t                 state;
  st_t                 after_flush;
  logic                act;
  logic [TAG_W-1:0]    len_q;
  logic                key_q;
  logic                flush_last;
  logic                reflush;
  logic                keyframes_seen;
  logic [BUF_W-1:0]    buffered_bytes;
  logic [POS_W-1:0]    stream_position;
  logic [TAG_W-1:0]    left;
  logic [TAG_W-1:0]    offset;
  logic                first;
  logic                chunk_key;
  logic [THRESH_W-1:0] flush_limit;

  // output register
  logic                out_valid;
  logic [POS_W-1:0]    out_pos;
  logic [PLEN_W-1:0]   out_len;
  logic                out_fb;
  logic [TAG_W-1:0]    out_off;
  logic                out_cont;
  logic                out_last;
  logic                out_rej;

  // shared adder
  logic [POS_W-1:0]    add_a;
  logic [POS_W-1:0]    add_b;
  logic [POS_W-1:0]    add_sum;

  logic                emit_ok;
  logic                emit_fire;
  logic                in_fire;
  logic                cfg_wr;
  logic [BUF_W-1:0]    chunk_n;
  logic                chunk_final;
  logic                buf_empty;
  logic                len_zero;
  logic                len_gt_thr;

  assign emit_ok     = !out_valid || m_tready;
  // a new packet enters the output register this cycle
  assign emit_fire   = emit_ok &&
                       (state == ST_FLUSH || state == ST_CHUNK || state == ST_REJECT);
  assign s_tready    = (state == ST_IDLE);
  assign in_fire     = s_tvalid && s_tready;
  assign cfg_wr      = psel && penable && pwrite;
  assign chunk_final = ({12'd0, left} <= MAX_PKT_C);
  assign chunk_n     = chunk_final ? BUF_W'(left) : BUF_W'(MAX_PACKET);
  assign buf_empty   = (buffered_bytes == '0);
  assign len_zero    = (len_q == '0);
  assign len_gt_thr  = ({12'd0, len_q} > {17'd0, flush_limit});

  // operand select for the one adder
  always_comb begin
    add_a = stream_position;
    add_b = '0;
    unique case (state)
      ST_DECIDE: begin
        add_a = POS_W'(buffered_bytes);
        add_b = POS_W'(len_q);
      end
      ST_FLUSH: add_b = POS_W'(buffered_bytes);
      ST_CHUNK: add_b = POS_W'(chunk_n);
      default:  add_b = '0;
    endcase
  end
  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      after_flush     <= ST_IDLE;
      flush_last      <= 1'b0;
      reflush         <= 1'b0;
      keyframes_seen  <= 1'b0;
      buffered_bytes  <= '0;
      stream_position <= '0;
      first           <= 1'b0;
      chunk_key       <= 1'b0;
      flush_limit     <= mtpa_pkg::THRESH_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == mtpa_pkg::REG_FLUSH_LIMIT) begin
        flush_limit <= pwdata[THRESH_W-1:0];
      end
      if (out_valid && m_tready && !emit_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            len_q <= s_tdata[TAG_W-1:0];
            act   <= s_tuser[0];
            key_q <= s_tuser[1];
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          left   <= len_q;
          offset <= '0;
          first  <= 1'b1;
          if (act == mtpa_pkg::ACT_HEADER) begin
            if (buf_empty) begin
              stream_position <= POS_W'(len_q);
              state           <= ST_IDLE;
            end else begin
              flush_last  <= 1'b1;
              after_flush <= ST_IDLE;
              state       <= ST_FLUSH;
            end
          end else if (POS_W'(len_q) > MAX_TAG_C) begin
            state <= ST_REJECT;
          end else if (key_q || add_sum > MAX_PKT_C) begin
            // keyframe or overflow: flush, then send the tag in chunks
            if (key_q) begin
              keyframes_seen <= 1'b1;
            end
            chunk_key <= key_q;
            if (!buf_empty) begin
              flush_last  <= len_zero;
              after_flush <= len_zero ? ST_IDLE : ST_CHUNK;
              state       <= ST_FLUSH;
            end else begin
              state <= len_zero ? ST_IDLE : ST_CHUNK;
            end
          end else if (add_sum > {17'd0, flush_limit}) begin
            // threshold crossed: flush, re-buffer, maybe flush again
            reflush <= len_gt_thr;
            if (!buf_empty) begin
              flush_last  <= !len_gt_thr;
              after_flush <= ST_REBUF;
              state       <= ST_FLUSH;
            end else begin
              state <= ST_REBUF;
            end
          end else begin
            buffered_bytes <= BUF_W'(add_sum);
            state          <= ST_IDLE;
          end
        end

        ST_FLUSH: begin
          if (emit_ok) begin
            out_valid      <= 1'b1;
            out_pos        <= stream_position;
            out_len        <= PLEN_W'(buffered_bytes);
            out_fb         <= 1'b1;
            out_off        <= '0;
            out_cont       <= keyframes_seen;
            out_last       <= flush_last;
            out_rej        <= 1'b0;
            buffered_bytes <= '0;
            if (act == mtpa_pkg::ACT_HEADER) begin
              stream_position <= POS_W'(len_q);
            end else begin
              stream_position <= add_sum;
            end
            state <= after_flush;
          end
        end

        ST_REBUF: begin
          buffered_bytes <= BUF_W'(len_q);
          if (reflush) begin
            flush_last  <= 1'b1;
            after_flush <= ST_IDLE;
            state       <= ST_FLUSH;
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_CHUNK: begin
          if (emit_ok) begin
            out_valid       <= 1'b1;
            out_pos         <= stream_position;
            out_len         <= PLEN_W'(chunk_n);
            out_fb          <= 1'b0;
            out_off         <= offset;
            out_cont        <= keyframes_seen && !(first && chunk_key);
            out_last        <= chunk_final;
            out_rej         <= 1'b0;
            stream_position <= add_sum;
            offset          <= offset + TAG_W'(chunk_n);
            left            <= left - TAG_W'(chunk_n);
            first           <= 1'b0;
            if (chunk_final) begin
              state <= ST_IDLE;
            end
          end
        end

        ST_REJECT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            out_pos   <= stream_position;
            out_len   <= '0;
            out_fb    <= 1'b0;
            out_off   <= '0;
            out_cont  <= 1'b0;
            out_last  <= 1'b1;
            out_rej   <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_off, out_len, out_pos};
  assign m_tuser  = {out_rej, out_cont, out_fb};
  assign m_tlast  = out_last;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mtpa_pkg::REG_FLUSH_LIMIT)
                  ? {17'd0, flush_limit} : 32'd0;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    POS_W'(buffered_bytes) <= MAX_PKT_C)
    else $error("buffered byte count above max packet");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rej |-> out_last && out_len == '0 && !out_fb)
    else $error("rejected transaction malformed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("sequencer ready right after accepting a tag");

  a_chunk_size: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHUNK |-> chunk_n != '0 && POS_W'(chunk_n) <= MAX_PKT_C)
    else $error("chunk size out of range");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> !buf_empty)
    else $error("flush of empty buffer");

endmodule

// ===== verif/mtpa_packet_checker.sv =====
// ----------------------------------------------------------------------------
// mtpa_packet_checker
// Watches the tag, packet and APB channels of the media tag packet
// aggregator, predicts the packets of each accepted tag and compares.
// ----------------------------------------------------------------------------
module mtpa_packet_checker
  import mtpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] tag_length, [23:20] zero
  input  logic [1:0]  s_tuser,   // [0] action, [1] is_keyframe
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // [31:0] position, [46:32] length, [66:47] offset
  input  logic [2:0]  m_tuser,   // [0] from_buffer, [1] continuation, [2] rejected
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PKT_MAX = MAX_PACKET_DEF;
  localparam int unsigned TAG_MAX = MAX_CHUNKS_DEF * MAX_PACKET_DEF;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [PLEN_W-1:0] length;
    logic              from_buffer;
    logic [TAG_W-1:0]  offset;
    logic              continuation;
    logic              last;
    logic              rejected;
  } packet_t;

  packet_t             expected_packets[$];
  logic [THRESH_W-1:0] flush_thresh;
  logic [PLEN_W-1:0]   agg_bytes;
  logic [POS_W-1:0]    stream_pos;
  logic                key_seen;
  int                  new_count;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void emit_packet(int unsigned len, logic from_buf,
                                      logic [TAG_W-1:0] off, logic cont, logic rej);
    packet_t p;
    p.position     = stream_pos;
    p.length       = PLEN_W'(len);
    p.from_buffer  = from_buf;
    p.offset       = off;
    p.continuation = cont;
    p.last         = 1'b0;
    p.rejected     = rej;
    expected_packets.push_back(p);
    stream_pos = stream_pos + len;
    new_count++;
  endfunction

  function automatic void flush_aggregate();
    if (agg_bytes != '0) begin
      emit_packet(agg_bytes, 1'b1, '0, key_seen, 1'b0);
      agg_bytes = '0;
    end
  endfunction

  function automatic void send_chunks(int unsigned len, logic key);
    int unsigned      left;
    int unsigned      n;
    logic [TAG_W-1:0] off;
    logic             first;
    left  = len;
    off   = '0;
    first = 1'b1;
    while (left != 0) begin
      n = (left > PKT_MAX) ? PKT_MAX : left;
      // first chunk of a keyframe starts a group of pictures
      emit_packet(n, 1'b0, off, key_seen && !(first && key), 1'b0);
      off   = off + TAG_W'(n);
      left  = left - n;
      first = 1'b0;
    end
  endfunction

  function automatic void predict_packets(logic act, logic [TAG_W-1:0] len, logic key);
    int unsigned total;
    packet_t     tail;
    new_count = 0;
    total     = 32'(agg_bytes) + 32'(len);
    if (act == ACT_HEADER) begin
      flush_aggregate();
      stream_pos = POS_W'(len);
    end else if (len > TAG_MAX) begin
      emit_packet(0, 1'b0, '0, 1'b0, 1'b1);
    end else if (key) begin
      key_seen = 1'b1;
      flush_aggregate();
      send_chunks(len, 1'b1);
    end else if (total > PKT_MAX) begin
      flush_aggregate();
      send_chunks(len, 1'b0);
    end else if (total > flush_thresh) begin
      flush_aggregate();
      agg_bytes = PLEN_W'(len);
      if (agg_bytes > flush_thresh)
        flush_aggregate();
    end else begin
      agg_bytes = PLEN_W'(total);
    end
    if (new_count > 0) begin
      tail      = expected_packets.pop_back();
      tail.last = 1'b1;
      expected_packets.push_back(tail);
    end
  endfunction

  task automatic check_packet();
    packet_t want;
    if (expected_packets.size() == 0) begin
      report_mismatch("packet with nothing expected (position)", m_tdata[31:0], 0);
    end else begin
      want = expected_packets.pop_front();
      if (m_tdata[31:0] !== want.position)
        report_mismatch("packet_position", m_tdata[31:0], want.position);
      if (m_tdata[46:32] !== want.length)
        report_mismatch("packet_length", m_tdata[46:32], want.length);
      if (m_tuser[0] !== want.from_buffer)
        report_mismatch("from_buffer", m_tuser[0], want.from_buffer);
      if (m_tdata[66:47] !== want.offset)
        report_mismatch("chunk_offset", m_tdata[66:47], want.offset);
      if (m_tuser[1] !== want.continuation)
        report_mismatch("continuation", m_tuser[1], want.continuation);
      if (m_tlast !== want.last)
        report_mismatch("last_result", m_tlast, want.last);
      if (m_tuser[2] !== want.rejected)
        report_mismatch("rejected", m_tuser[2], want.rejected);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      flush_thresh = THRESH_RESET;
      agg_bytes    = '0;
      stream_pos   = '0;
      key_seen     = 1'b0;
      fail_count   = 0;
      expected_packets.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_packet();
      if (psel && penable && pwrite && pready && paddr[2] == REG_FLUSH_LIMIT)
        flush_thresh = pwdata[THRESH_W-1:0];
      if (s_tvalid && s_tready)
        predict_packets(s_tuser[0], s_tdata[TAG_W-1:0], s_tuser[1]);
    end
    pending = expected_packets.size();
  end

endmodule

// ===== verif/media_tag_packet_aggregator_tb.sv =====
// ----------------------------------------------------------------------------
// media_tag_packet_aggregator_tb
// Drives tags, headers and threshold writes into the aggregator with random
// gaps and back-pressure; the checker predicts and compares every packet.
// ----------------------------------------------------------------------------
module media_tag_packet_aggregator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtpa_pkg::*;

  // APB byte addresses: threshold word and an unmapped word
  localparam logic [2:0] THRESH_ADDR = {REG_FLUSH_LIMIT, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = 3'b100;

  localparam int unsigned TAG_MAX     = MAX_CHUNKS_DEF * MAX_PACKET_DEF;
  localparam int unsigned TAG_ALL_ONE = (1 << TAG_W) - 1;
  localparam int          HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int          PHASE_ITEMS = 64;      // random tags per threshold phase
  localparam int unsigned CYCLE_LIMIT = 400000;  // far above the slowest legal run

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [19:0] tag_length, [23:20] zero
  logic [1:0]  s_tuser;   // [0] action, [1] is_keyframe
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [31:0] position, [46:32] length, [66:47] offset, [71:67] zero
  logic [2:0]  m_tuser;   // [0] from_buffer, [1] continuation, [2] rejected
  logic        m_tlast;   // last_result
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // stimulus knobs shared with the receiver process
  bit no_idle;
  bit hold_req;

  media_tag_packet_aggregator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mtpa_packet_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Packet receiver: about 6% random stalls, none while no_idle is set.
  // A hold request parks tready low for HOLD_CYCLES so the sequencer backs
  // up and s_tready drops while the sender keeps offering.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 6) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: covers a hang or expectations that never drain
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // One tag transaction. Entered and left at a falling edge; valid stays
  // high between back-to-back tags unless a random gap is taken.
  task automatic send_tag(logic act, logic [TAG_W-1:0] len, logic key);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, len};
    s_tuser  <= {key, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup phase, access phase, then the bus is released
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every predicted packet is out and the sequencer is back idle.
  // Tags that only buffer leave nothing pending, so s_tready is checked as well.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || !s_tready) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Random tag mix: mostly small aggregating tags, some keyframes and
  // overflows, a few huge multi-chunk tags, rejects, headers and raw noise.
  task automatic random_tag();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      send_tag(ACT_TAG, TAG_W'($urandom_range(0, 3000)), 1'b0);
    else if (pick < 55)
      send_tag(ACT_TAG, TAG_W'($urandom_range(3000, MAX_PACKET_DEF)), 1'b0);
    else if (pick < 62)   // hugs the packet overflow edge
      send_tag(ACT_TAG, TAG_W'($urandom_range(MAX_PACKET_DEF - 400, MAX_PACKET_DEF + 4)),
               1'b0);
    else if (pick < 75)
      send_tag(ACT_TAG, TAG_W'($urandom_range(0, 40000)), 1'b1);
    else if (pick < 78)
      send_tag(ACT_TAG, TAG_W'($urandom_range(40000, TAG_MAX)), 1'($urandom));
    else if (pick < 84)
      send_tag(ACT_TAG, TAG_W'($urandom_range(TAG_MAX + 1, TAG_ALL_ONE)), 1'($urandom));
    else if (pick < 96)
      send_tag(ACT_HEADER, TAG_W'($urandom), 1'($urandom));
    else
      send_tag(1'($urandom), TAG_W'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [31:0] thresh;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed: reset threshold, no keyframe seen yet ---
    send_tag(ACT_TAG, TAG_W'(0), 1'b0);                  // zero length appends quietly
    send_tag(ACT_TAG, TAG_W'(5000), 1'b0);
    send_tag(ACT_TAG, TAG_W'(4000), 1'b0);               // threshold flush, re-buffer
    send_tag(ACT_TAG, TAG_W'(9000), 1'b0);               // still over: double flush
    send_tag(ACT_TAG, TAG_W'(100), 1'b0);
    send_tag(ACT_TAG, TAG_W'(16300), 1'b0);              // overflow: flush then one chunk
    send_tag(ACT_TAG, TAG_W'(MAX_PACKET_DEF), 1'b0);     // exactly max: buffered, flushed
    send_tag(ACT_TAG, TAG_W'(MAX_PACKET_DEF + 1), 1'b0);
    send_tag(ACT_TAG, TAG_W'(0), 1'b1);                  // zero keyframe, empty buffer
    send_tag(ACT_TAG, TAG_W'(200), 1'b0);
    send_tag(ACT_TAG, TAG_W'(0), 1'b1);                  // zero keyframe only flushes
    send_tag(ACT_TAG, TAG_W'(40000), 1'b1);              // keyframe split in three
    send_tag(ACT_TAG, TAG_W'(TAG_MAX), 1'b0);            // longest legal tag, max chunks
    send_tag(ACT_TAG, TAG_W'(TAG_MAX + 1), 1'b0);        // just over: rejected
    send_tag(ACT_TAG, TAG_W'(TAG_ALL_ONE), 1'b1);        // rejected keyframe
    send_tag(ACT_TAG, TAG_W'(300), 1'b0);
    send_tag(ACT_HEADER, TAG_W'(TAG_ALL_ONE), 1'b1);     // header flushes, key bit ignored
    send_tag(ACT_HEADER, TAG_W'(0), 1'b0);               // header with empty buffer
    send_tag(ACT_TAG, TAG_W'(MAX_PACKET_DEF), 1'b1);
    send_tag(ACT_TAG, TAG_W'(0), 1'b0);
    send_tag(ACT_HEADER, 20'hAAAAA, 1'b0);
    send_tag(ACT_TAG, 20'h05555, 1'b0);
    send_tag(ACT_HEADER, 20'h55555, 1'b1);

    // --- random phases, one threshold setting each ---
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1:       thresh = 1;
          2:       thresh = MAX_PACKET_DEF;
          3:       thresh = 0;                 // any nonempty buffer flushes
          4:       thresh = (1 << THRESH_W) - 1;
          default: thresh = $urandom_range(1, MAX_PACKET_DEF);
        endcase
        write_reg(THRESH_ADDR, thresh);
        if (phase == 5)
          write_reg(UNUSED_ADDR, $urandom);    // unmapped word, must not stick
      end
      no_idle = (phase == 2);                  // one phase at full rate on both sides
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 1 && i == 10)
          hold_req = 1'b1;
        random_tag();
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
